### rtl/core/open_syncmer_detector_defines.svh
// Assertion macros shared by the open-syncmer detector RTL.
`ifndef OPEN_SYNCMER_DETECTOR_DEFINES_SVH
`define OPEN_SYNCMER_DETECTOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside of reset.
`define OSD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("osd assertion failed");

// Condition must never be true outside of reset.
`define OSD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("osd forbidden condition seen");

`else

`define OSD_ASSERT(label, prop)
`define OSD_ASSERT_NEVER(label, cond)

`endif

`endif

### rtl/core/osd_pkg.sv
// Shared types, constants and functions of the open-syncmer detector.
`timescale 1ns / 1ps
package osd_pkg;

    // Character and field widths
    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 30;
    localparam int POS_W    = 32;
    localparam int OFFSET_W = 4;

    // Bit that folds ASCII letters to lower case
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    // Job queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // 2-bit nucleotide codes
    localparam logic [1:0] NT_A = 2'd0;
    localparam logic [1:0] NT_C = 2'd1;
    localparam logic [1:0] NT_G = 2'd2;
    localparam logic [1:0] NT_T = 2'd3;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Map an ASCII character to its 2-bit code; anything but C, G, T codes as A
    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] l;
        logic [1:0]        v;
        l = c | CASE_BIT;
        case (l)
            8'h63:   v = NT_C;
            8'h67:   v = NT_G;
            8'h74:   v = NT_T;
            default: v = NT_A;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/osd_front.sv
// Front end: takes characters, keeps the k-mer window and emits full-window jobs.
`timescale 1ns / 1ps
module osd_front #(
    parameter int KMER_LEN = 15
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [osd_pkg::CHAR_W-1:0]             i_base,
    input  logic                                   i_sequence_start,
    input  osd_pkg::t_q_stat                       i_q_stat,
    output logic                                   o_push,
    output logic [KMER_LEN*osd_pkg::CHAR_W+osd_pkg::POS_W-1:0] o_job
);
    import osd_pkg::*;

    localparam int FILL_W = $clog2(KMER_LEN + 1);

    logic [CHAR_W-1:0] r_win [KMER_LEN];
    logic [CHAR_W-1:0] n_win [KMER_LEN];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic              w_accept;
    logic [POS_W-1:0]  w_pos;

    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;

    // Shift in the new character, clearing first on a new sequence
    always_comb begin
        for (int i = 0; i < KMER_LEN - 1; i++) begin
            n_win[i] = i_sequence_start ? '0 : r_win[i+1];
        end
        n_win[KMER_LEN-1] = i_base;
        if (i_sequence_start) begin
            n_fill = FILL_W'(1);
        end else if (r_fill < FILL_W'(KMER_LEN)) begin
            n_fill = r_fill + FILL_W'(1);
        end else begin
            n_fill = r_fill;
        end
        n_cnt = (i_sequence_start ? '0 : r_cnt) + POS_W'(1);
    end

    assign w_pos = n_cnt - POS_W'(KMER_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
            r_cnt  <= n_cnt;
        end
    end

    // Window bytes carry no reset; the fill count gates their use
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < KMER_LEN; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // Hand a job to the queue once the window is full
    assign o_push = w_accept && (n_fill == FILL_W'(KMER_LEN));

    always_comb begin
        o_job = '0;
        for (int i = 0; i < KMER_LEN; i++) begin
            o_job[i*CHAR_W +: CHAR_W] = n_win[i];
        end
        o_job[KMER_LEN*CHAR_W +: POS_W] = w_pos;
    end

endmodule

### rtl/core/osd_queue.sv
// Two-entry job queue between the front end and the s-mer scanner.
`timescale 1ns / 1ps
`include "open_syncmer_detector_defines.svh"
module osd_queue #(
    parameter int WIDTH = 152
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output osd_pkg::t_q_stat o_stat
);
    import osd_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rd_data    = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    `OSD_ASSERT_NEVER(a_no_overflow, i_push && o_stat.full)
    `OSD_ASSERT_NEVER(a_no_underflow, i_pop && o_stat.empty)

endmodule

### rtl/core/osd_back.sv
// Back end: scans the s-mers of one window and emits the k-mer on an offset match.
`timescale 1ns / 1ps
`include "open_syncmer_detector_defines.svh"
module osd_back #(
    parameter int KMER_LEN = 15,
    parameter int SMER_LEN = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  osd_pkg::t_q_stat                       i_q_stat,
    input  logic [KMER_LEN*osd_pkg::CHAR_W+osd_pkg::POS_W-1:0] i_job,
    output logic                                   o_pop,
    input  logic [osd_pkg::OFFSET_W-1:0]           i_begin_offset,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [osd_pkg::CODE_W-1:0]             o_kmer_code,
    output logic [osd_pkg::POS_W-1:0]              o_kmer_position
);
    import osd_pkg::*;

    localparam int KS     = KMER_LEN - SMER_LEN;
    localparam int OW     = $clog2(KMER_LEN);
    localparam int SW     = SMER_LEN * CHAR_W;
    localparam int FULL_W = 2 * KMER_LEN;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CHAR_W-1:0]   r_scan [KMER_LEN];
    logic [SW-1:0]       r_min;
    logic [OW-1:0]       r_off, r_best;
    logic                r_out_valid;
    logic [CODE_W-1:0]   r_code;
    logic [POS_W-1:0]    r_pos;

    logic [CHAR_W-1:0]      w_win [KMER_LEN];
    logic [SW-1:0]          w_first;
    logic [SW-1:0]          w_cand;
    logic                   w_less;
    logic [FULL_W-1:0]      w_full_code;
    logic [FULL_W+CODE_W-1:0] w_code_ext;
    logic                   w_match;

    // Unpack the job and build the folded first s-mer and the packed code
    always_comb begin
        for (int i = 0; i < KMER_LEN; i++) begin
            w_win[i] = i_job[i*CHAR_W +: CHAR_W];
        end
        for (int i = 0; i < SMER_LEN; i++) begin
            w_first[(SMER_LEN-1-i)*CHAR_W +: CHAR_W] = w_win[i] | CASE_BIT;
        end
        for (int i = 0; i < KMER_LEN; i++) begin
            w_full_code[(KMER_LEN-1-i)*2 +: 2] = base_code(w_win[i]);
        end
    end

    assign w_code_ext = {{CODE_W{1'b0}}, w_full_code};

    // Candidate s-mer always sits at the head of the shifting scan window
    always_comb begin
        for (int i = 0; i < SMER_LEN; i++) begin
            w_cand[(SMER_LEN-1-i)*CHAR_W +: CHAR_W] = r_scan[i] | CASE_BIT;
        end
    end

    assign w_less  = (w_cand < r_min);
    assign w_match = ((OW+OFFSET_W)'(r_best) == (OW+OFFSET_W)'(i_begin_offset));
    assign o_pop   = (r_state == S_IDLE) && !i_q_stat.empty;

    // Sequencer: load, scan one offset per cycle, decide, present result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        for (int i = 0; i < KMER_LEN - 1; i++) begin
                            r_scan[i] <= w_win[i+1];
                        end
                        r_scan[KMER_LEN-1] <= w_win[KMER_LEN-1];
                        r_min  <= w_first;
                        r_best <= '0;
                        r_off  <= OW'(1);
                        r_code <= w_code_ext[CODE_W-1:0];
                        r_pos  <= i_job[KMER_LEN*CHAR_W +: POS_W];
                        r_state <= (KS == 0) ? S_DECIDE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_less) begin
                        r_min  <= w_cand;
                        r_best <= r_off;
                    end
                    for (int i = 0; i < KMER_LEN - 1; i++) begin
                        r_scan[i] <= r_scan[i+1];
                    end
                    if (r_off == OW'(KS)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_off <= r_off + OW'(1);
                    end
                end
                S_DECIDE: begin
                    if (w_match) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kmer_code     = r_code;
    assign o_kmer_position = r_pos;

    `OSD_ASSERT(a_off_range, (r_state == S_SCAN) |-> (r_off != '0 && r_off <= OW'(KS)))
    `OSD_ASSERT(a_valid_in_out, r_out_valid |-> (r_state == S_OUT))

endmodule

### rtl/core/open_syncmer_detector.sv
// Top level of the open-syncmer detector: front end, job queue, scanner.
// A result is valid once its window job is popped and loaded, scanned at each later s-mer
//   offset in turn and decided; the job may wait in the queue while the scanner is busy.
// The scanner takes a new window only when idle, after its decision and any emitted result,
//   held by m_axis_tready; input takes a character per cycle while the queue has room.
// Reset: synchronous, active low; empties the queue, clears counters, valid and begin_offset.
`timescale 1ns / 1ps
module open_syncmer_detector #(
    parameter int KMER_LEN = 15,
    parameter int SMER_LEN = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: begin_offset
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] base
    input  logic        s_axis_tuser,   // [0] sequence_start
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [29:0] kmer_code, [61:30] kmer_position, zero above
);
    import osd_pkg::*;

    localparam int JOB_W = KMER_LEN * CHAR_W + POS_W;

    logic [OFFSET_W-1:0] r_begin_offset;
    t_q_stat             w_q_stat;
    logic                w_push, w_pop;
    logic [JOB_W-1:0]    w_job_in, w_job_out;
    logic [CODE_W-1:0]   w_code;
    logic [POS_W-1:0]    w_pos;

    // Hold the configured offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_offset <= '0;
        end else if (i_cfg_we) begin
            r_begin_offset <= i_cfg_wdata;
        end
    end

    osd_front #(
        .KMER_LEN (KMER_LEN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_base           (s_axis_tdata),
        .i_sequence_start (s_axis_tuser),
        .i_q_stat         (w_q_stat),
        .o_push           (w_push),
        .o_job            (w_job_in)
    );

    osd_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_job_in),
        .i_pop     (w_pop),
        .o_rd_data (w_job_out),
        .o_stat    (w_q_stat)
    );

    osd_back #(
        .KMER_LEN (KMER_LEN),
        .SMER_LEN (SMER_LEN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (w_q_stat),
        .i_job           (w_job_out),
        .o_pop           (w_pop),
        .i_begin_offset  (r_begin_offset),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_kmer_code     (w_code),
        .o_kmer_position (w_pos)
    );

    assign m_axis_tdata = {2'b00, w_pos, w_code};

endmodule

### tb/tb.sv
// Self-checking testbench for the open-syncmer detector: directed windows, offset sweeps, stalls.
`timescale 1ns / 1ps
module tb;
    import osd_pkg::*;

    localparam int KMER_LEN           = 15;
    localparam int SMER_LEN           = 4;
    localparam int LAST_OFFSET        = KMER_LEN - SMER_LEN;
    // Two queued windows plus one in the scanner, each a full scan, with margin
    localparam int SCAN_SETTLE_CYCLES = 64;
    localparam int RESULT_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT        = 2000;

    // Folded (lower case) nucleotide letters
    localparam logic [CHAR_W-1:0] LC_C = "c";
    localparam logic [CHAR_W-1:0] LC_G = "g";
    localparam logic [CHAR_W-1:0] LC_T = "t";

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [POS_W-1:0]  pos;
    } t_kmer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] base
    logic        s_axis_tuser;   // [0] sequence_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [29:0] kmer_code, [61:30] kmer_position, zero above

    // Predictor state
    logic [CHAR_W-1:0]   win_chars [KMER_LEN];
    int                  fill_count;
    logic [POS_W-1:0]    char_count;
    logic [OFFSET_W-1:0] offset_cfg;
    t_kmer               kmer_expected [$];
    t_kmer               want;

    int mismatch_count;
    int idle_cycles;
    bit hold_results;
    bit tx_steady;
    bit rx_steady;

    open_syncmer_detector #(
        .KMER_LEN (KMER_LEN),
        .SMER_LEN (SMER_LEN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // 2-bit code of a character; anything but C, G, T counts as A
    function automatic logic [1:0] nt_code(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] l;
        l = c | CASE_BIT;
        if (l == LC_C) return NT_C;
        if (l == LC_G) return NT_G;
        if (l == LC_T) return NT_T;
        return NT_A;
    endfunction

    // True when the s-mer at cand sorts strictly below the one at cur
    function automatic bit smer_below(input int cand, input int cur);
        logic [CHAR_W-1:0] x;
        logic [CHAR_W-1:0] y;
        for (int i = 0; i < SMER_LEN; i++) begin
            x = win_chars[cur + i] | CASE_BIT;
            y = win_chars[cand + i] | CASE_BIT;
            if (x != y) return y < x;
        end
        return 1'b0;
    endfunction

    // Advance the window by one character and queue the k-mer if it is a syncmer
    function automatic void predict_syncmer(input logic [CHAR_W-1:0] b, input logic first);
        int                    best;
        logic [2*KMER_LEN-1:0] code;
        t_kmer                 hit;
        if (first) begin
            foreach (win_chars[i]) win_chars[i] = '0;
            fill_count = 0;
            char_count = '0;
        end
        for (int i = 0; i < KMER_LEN - 1; i++) win_chars[i] = win_chars[i + 1];
        win_chars[KMER_LEN - 1] = b;
        if (fill_count < KMER_LEN) fill_count++;
        char_count = char_count + 1;
        if (fill_count < KMER_LEN) return;
        best = 0;
        for (int off = 1; off <= LAST_OFFSET; off++) begin
            if (smer_below(off, best)) best = off;
        end
        if (best != int'(offset_cfg)) return;
        code = '0;
        for (int i = 0; i < KMER_LEN; i++) code = {code[2*KMER_LEN-3:0], nt_code(win_chars[i])};
        hit.code = code[CODE_W-1:0];
        hit.pos  = char_count - POS_W'(KMER_LEN);
        kmer_expected = {kmer_expected, hit};
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly nucleotides in either case, some arbitrary bytes
    function automatic logic [CHAR_W-1:0] pick_base();
        logic [CHAR_W-1:0] letters [8];
        letters = '{"A", "C", "G", "T", "a", "c", "g", "t"};
        if ($urandom_range(0, 99) < 88) return letters[$urandom_range(0, 7)];
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Offer one character and hold it until the block takes it
    task automatic send_base(input logic [CHAR_W-1:0] b, input logic first);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_syncmer(b, first);
    endtask

    // Drop valid and hold it low for the gap given by n
    task automatic drop_input(input int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop sending, wait for all results, then let the scanner finish silent windows
    task automatic settle_block();
        drop_input(1);
        while (kmer_expected.size() != 0) @(posedge i_clk);
        repeat (SCAN_SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_begin_offset(input logic [OFFSET_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        offset_cfg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random sequences: mostly full windows, some cut short, some long
    task automatic send_genome(input int n_items);
        int sent;
        int seq_len;
        int r;
        int gap;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 80) seq_len = $urandom_range(KMER_LEN, 50);
            else if (r < 90) seq_len = $urandom_range(1, KMER_LEN - 1);
            else seq_len = $urandom_range(60, 150);
            for (int i = 0; i < seq_len && sent < n_items; i++) begin
                gap = tx_steady ? 0 : pick_gap();
                if (gap > 0) drop_input(gap);
                send_base(pick_base(), i == 0);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [OFFSET_W-1:0] offset, input int n_items);
        settle_block();
        write_begin_offset(offset);
        send_genome(n_items);
    endtask

    // Hand-built windows: minimum at the last offset, case folding, a non-letter byte,
    // a tie that the leftmost s-mer wins, and a restart in mid-window
    task automatic test_directed();
        logic [CHAR_W-1:0] chars [17];
        chars = '{"T", "t", "G", "g", "C", "c", "T", "z", 8'hFF, "G", "c",
                  "A", "a", "A", "a", "A", "C"};
        write_begin_offset(OFFSET_W'(LAST_OFFSET));
        for (int i = 0; i < 17; i++) send_base(chars[i], i == 0 || i == 16);
        settle_block();
        write_begin_offset('0);
        send_base(8'h00, 1'b1);
        for (int i = 1; i < KMER_LEN + 2; i++) send_base(8'h00, 1'b0);
    endtask

    // Extreme offsets, an offset that never matches, and random ones
    task automatic test_offset_sweep();
        tx_steady = 1'b1;
        run_phase('0, 250);
        tx_steady = 1'b0;
        rx_steady = 1'b1;
        run_phase(OFFSET_W'(LAST_OFFSET), 200);
        rx_steady = 1'b0;
        run_phase('1, 60);
        repeat (3) run_phase(OFFSET_W'($urandom_range(1, LAST_OFFSET - 1)), 150);
    endtask

    // Hold off results so the block backs up, then pause the sender until drained
    task automatic test_backpressure();
        settle_block();
        write_begin_offset(OFFSET_W'($urandom_range(0, LAST_OFFSET)));
        tx_steady    = 1'b1;
        hold_results = 1'b1;
        send_genome(120);
        tx_steady = 1'b0;
        settle_block();
        send_genome(100);
    endtask

    // Stimulus
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        foreach (win_chars[i]) win_chars[i] = '0;
        fill_count     = 0;
        char_count     = '0;
        offset_cfg     = '0;
        mismatch_count = 0;
        hold_results   = 1'b0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_offset_sweep();
        test_backpressure();

        settle_block();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side ready: random stalls, or one long hold on request
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                m_axis_tready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end else begin
                stall = rx_steady ? 0 : pick_gap();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Compare each result transaction with the oldest expected k-mer
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (kmer_expected.size() == 0) begin
                $error("result with none expected: tdata=%h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = kmer_expected.pop_front();
                if (m_axis_tdata[CODE_W-1:0] !== want.code) begin
                    $error("kmer_code: expected %h, got %h", want.code,
                           m_axis_tdata[CODE_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[CODE_W+POS_W-1:CODE_W] !== want.pos) begin
                    $error("kmer_position: expected %0d, got %0d", want.pos,
                           m_axis_tdata[CODE_W+POS_W-1:CODE_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### open_syncmer_detector.f
+incdir+rtl/core
rtl/core/osd_pkg.sv
rtl/core/osd_front.sv
rtl/core/osd_queue.sv
rtl/core/osd_back.sv
rtl/core/open_syncmer_detector.sv
tb/tb.sv
